// ----- rtl/jds_pkg.sv -----
// Shared types and constants for the unit job deadline scheduler.
package jds_pkg;

  localparam int BonusW    = 16;
  localparam int DeadlineW = 10;
  localparam int SumW      = 24;
  localparam int WcountW   = 5;
  localparam int LoadW     = 10;

  typedef struct packed {
    logic                 valid;
    logic [DeadlineW-1:0] deadline;
    logic [BonusW-1:0]    bonus;
  } task_entry_t;

  typedef struct packed {
    logic              valid;
    logic [BonusW-1:0] bonus;
  } bonus_entry_t;

  typedef enum logic [1:0] {
    TOP_HOLD,
    TOP_INS,
    TOP_POP
  } task_op_t;

  typedef enum logic [1:0] {
    BOP_HOLD,
    BOP_INS,
    BOP_REP,
    BOP_CLR
  } bonus_op_t;

  typedef enum logic {
    ST_LOAD,
    ST_SCHED
  } state_t;

endpackage

// ----- rtl/jds_task_cell.sv -----
// One cell of the task chain, kept sorted by rising deadline in arrival order.
module jds_task_cell #(
  parameter bit HEAD = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  jds_pkg::task_op_t   op,
  input  jds_pkg::task_entry_t new_entry,
  input  jds_pkg::task_entry_t prev,
  input  jds_pkg::task_entry_t next,
  output jds_pkg::task_entry_t own
);

  jds_pkg::task_entry_t own_next;

  always_comb begin
    own_next = own;
    unique case (op)
      jds_pkg::TOP_INS: begin
        // Equal deadlines keep arrival order: a new task goes behind them.
        if (!HEAD && prev.valid && prev.deadline > new_entry.deadline) begin
          own_next = prev;
        end else if ((HEAD || prev.valid) &&
                     (!own.valid || own.deadline > new_entry.deadline)) begin
          own_next = new_entry;
        end
      end
      jds_pkg::TOP_POP: own_next = next;
      default: own_next = own;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own.valid <= 1'b0;
    end else begin
      own <= own_next;
    end
  end

endmodule

// ----- rtl/jds_bonus_cell.sv -----
// One cell of the accepted-bonus chain, kept sorted by rising bonus.
module jds_bonus_cell #(
  parameter bit HEAD = 1'b0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  jds_pkg::bonus_op_t          op,
  input  logic [jds_pkg::BonusW-1:0]  bonus_in,
  input  jds_pkg::bonus_entry_t       prev,
  input  jds_pkg::bonus_entry_t       next,
  output jds_pkg::bonus_entry_t       own
);

  jds_pkg::bonus_entry_t own_next;
  jds_pkg::bonus_entry_t src_own;
  jds_pkg::bonus_entry_t src_prev;
  jds_pkg::bonus_entry_t ins_val;

  // A replace drops the head, so the chain is seen shifted by one first.
  always_comb begin
    src_own  = (op == jds_pkg::BOP_REP) ? next : own;
    src_prev = (op == jds_pkg::BOP_REP) ? own : prev;
    if (!HEAD && src_prev.valid && src_prev.bonus > bonus_in) begin
      ins_val = src_prev;
    end else if ((HEAD || src_prev.valid) &&
                 (!src_own.valid || src_own.bonus > bonus_in)) begin
      ins_val = '{valid: 1'b1, bonus: bonus_in};
    end else begin
      ins_val = src_own;
    end
  end

  always_comb begin
    unique case (op)
      jds_pkg::BOP_INS,
      jds_pkg::BOP_REP: own_next = ins_val;
      jds_pkg::BOP_CLR: own_next = '{valid: 1'b0, bonus: own.bonus};
      default:          own_next = own;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own.valid <= 1'b0;
    end else begin
      own <= own_next;
    end
  end

endmodule

// ----- rtl/unit_job_deadline_scheduler.sv -----
// Top level of the unit job deadline scheduler: task chain, bonus chain, workers.
//
// Input items arrive on the s_axis channel, one task per item: tdata carries
// the bonus and the deadline, tlast marks the final task of a set. While a set
// loads, one item is taken every cycle and inserted into a chain of cells kept
// sorted by deadline. Items that find the chain full are dropped and flagged.
// The item marked last closes the set; s_axis_tready then drops while the
// chain shifts its tasks out toward the scheduler, one task per cycle. Each
// task is placed on the first worker whose load is below its deadline, or else
// competes with the smallest accepted bonus, which sits at the head of a second
// sorted cell chain. Once all stored tasks are scheduled, the result is posted
// and the next set can begin to load. One result item per set leaves on
// m_axis: the saturated lost sum in tdata and the overflow flag in tuser.
// The result sits in an output register; if the receiver stalls, the next
// set still loads and schedules, and only its final posting waits until the
// previous result is taken. Reset empties both chains, clears all worker
// loads and the output valid flag, and sets the worker count register to one.
// cfg_data is written when cfg_we is high.
module unit_job_deadline_scheduler #(
  parameter int MAX_TASKS   = 256,
  parameter int MAX_WORKERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,         // worker_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,     // task_bonus[15:0], task_deadline[25:16], zeros
  input  logic        s_axis_tlast,     // last_task
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,     // lost_sum[23:0]
  output logic        m_axis_tuser      // overflow
);

  localparam int WIDX = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  jds_pkg::state_t state, state_next;

  logic [jds_pkg::WcountW-1:0] worker_count;
  logic                        overflow_seen;
  logic [jds_pkg::SumW-1:0]    sum;
  logic [jds_pkg::LoadW-1:0]   load [MAX_WORKERS];

  jds_pkg::task_op_t     t_op;
  jds_pkg::bonus_op_t    b_op;
  jds_pkg::task_entry_t  t_cell [MAX_TASKS];
  jds_pkg::bonus_entry_t b_cell [MAX_TASKS];
  jds_pkg::task_entry_t  t_new;
  jds_pkg::task_entry_t  head;

  logic                      in_acc;
  logic                      full;
  logic                      fit;
  logic [WIDX-1:0]           fit_idx;
  logic [jds_pkg::BonusW-1:0] lost_val;
  logic                      lose;
  logic [jds_pkg::SumW:0]    sum_wide;
  logic                      finish;

  assign s_axis_tready = (state == jds_pkg::ST_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = t_cell[MAX_TASKS-1].valid;
  assign head          = t_cell[0];
  assign t_new         = '{valid: 1'b1,
                           deadline: s_axis_tdata[25:16],
                           bonus: s_axis_tdata[15:0]};

  // Task chain: sorted insertion while loading, shift toward the head while scheduling.
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_task
    jds_pkg::task_entry_t prev_e, next_e;
    assign prev_e = (i == 0) ? '0 : t_cell[(i == 0) ? 0 : i-1];
    assign next_e = (i == MAX_TASKS-1) ? '0 : t_cell[(i == MAX_TASKS-1) ? i : i+1];
    jds_task_cell #(.HEAD(i == 0)) u_cell (
      .clk(clk), .rst(rst), .op(t_op), .new_entry(t_new),
      .prev(prev_e), .next(next_e), .own(t_cell[i])
    );
  end

  // Accepted bonuses: the smallest one is always in the head cell.
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_bonus
    jds_pkg::bonus_entry_t prev_e, next_e;
    assign prev_e = (i == 0) ? '0 : b_cell[(i == 0) ? 0 : i-1];
    assign next_e = (i == MAX_TASKS-1) ? '0 : b_cell[(i == MAX_TASKS-1) ? i : i+1];
    jds_bonus_cell #(.HEAD(i == 0)) u_cell (
      .clk(clk), .rst(rst), .op(b_op), .bonus_in(head.bonus),
      .prev(prev_e), .next(next_e), .own(b_cell[i])
    );
  end

  // First worker, within the active count, whose load is below the deadline.
  always_comb begin
    fit     = 1'b0;
    fit_idx = '0;
    for (int k = 0; k < MAX_WORKERS; k++) begin
      if (!fit && (k < int'(worker_count)) && (load[k] < head.deadline)) begin
        fit     = 1'b1;
        fit_idx = WIDX'(k);
      end
    end
  end

  assign finish = (state == jds_pkg::ST_SCHED) && !head.valid &&
                  (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    t_op       = jds_pkg::TOP_HOLD;
    b_op       = jds_pkg::BOP_HOLD;
    lose       = 1'b0;
    lost_val   = head.bonus;
    unique case (state)
      jds_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            t_op = jds_pkg::TOP_INS;
          end
          if (s_axis_tlast) begin
            state_next = jds_pkg::ST_SCHED;
          end
        end
      end
      jds_pkg::ST_SCHED: begin
        if (head.valid) begin
          t_op = jds_pkg::TOP_POP;
          if (fit) begin
            b_op = jds_pkg::BOP_INS;
          end else begin
            lose = 1'b1;
            if (b_cell[0].valid && b_cell[0].bonus < head.bonus) begin
              b_op     = jds_pkg::BOP_REP;
              lost_val = b_cell[0].bonus;
            end
          end
        end else if (finish) begin
          b_op       = jds_pkg::BOP_CLR;
          state_next = jds_pkg::ST_LOAD;
        end
      end
      default: state_next = jds_pkg::ST_LOAD;
    endcase
  end

  assign sum_wide = {1'b0, sum} + {{(jds_pkg::SumW+1-jds_pkg::BonusW){1'b0}}, lost_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jds_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count <= jds_pkg::WcountW'(1);
    end else if (cfg_we) begin
      worker_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
      sum           <= '0;
      for (int k = 0; k < MAX_WORKERS; k++) begin
        load[k] <= '0;
      end
    end else if (finish) begin
      overflow_seen <= 1'b0;
      sum           <= '0;
      for (int k = 0; k < MAX_WORKERS; k++) begin
        load[k] <= '0;
      end
    end else begin
      if (in_acc && full) begin
        overflow_seen <= 1'b1;
      end
      if (lose) begin
        sum <= sum_wide[jds_pkg::SumW] ? {jds_pkg::SumW{1'b1}} : sum_wide[jds_pkg::SumW-1:0];
      end
      if (state == jds_pkg::ST_SCHED && head.valid && fit) begin
        load[fit_idx] <= load[fit_idx] + jds_pkg::LoadW'(1);
      end
    end
  end

  // Output register holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_axis_tdata <= sum;
      m_axis_tuser <= overflow_seen;
    end
  end

endmodule
